[rtl/xse_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xse_pkg
// shared types, opcodes and constants for the x86 subset executor
// ----------------------------------------------------------------------------
package xse_pkg;

    localparam int STACK_WORDS_DEF = 1024;
    localparam int STACK_BYTES_W   = 13;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;
    localparam int NUM_REGS        = 8;
    localparam int REG_IDX_W       = 3;
    localparam int REG_EAX         = 0;
    localparam int REG_ESP         = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK = 2'd2;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_EXEC  = 1'b1;

    localparam logic [7:0] OP_ADD    = 8'h01;
    localparam logic [7:0] OP_SUB    = 8'h29;
    localparam logic [7:0] OP_PUSH_L = 8'h50;
    localparam logic [7:0] OP_PUSH_H = 8'h57;
    localparam logic [7:0] OP_POP_L  = 8'h58;
    localparam logic [7:0] OP_POP_H  = 8'h5F;
    localparam logic [7:0] OP_NOP    = 8'h90;
    localparam logic [7:0] OP_MOV_L  = 8'hB8;
    localparam logic [7:0] OP_MOV_H  = 8'hBF;
    localparam logic [7:0] OP_RET    = 8'hC3;
    localparam logic [7:0] OP_CALL   = 8'hE8;
    localparam logic [7:0] OP_JMP    = 8'hEB;

    typedef enum logic [2:0] {
        ST_RUN    = 3'd0,
        ST_HALT   = 3'd1,
        ST_BADOP  = 3'd2,
        ST_OVER   = 3'd3,
        ST_UNDER  = 3'd4,
        ST_BOUNDS = 3'd5,
        ST_EXT    = 3'd6
    } status_t;

    typedef struct packed {
        logic [NUM_REGS-1:0][31:0] regs;
        logic [31:0]               ip;
        logic                      stopped;
        status_t                   status;
    } cpu_state_t;

    typedef struct packed {
        logic        we;
        logic [31:0] data;
    } stk_wr_t;

endpackage
`default_nettype wire

[rtl/xse_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xse_cmd_if / xse_rsp_if
// valid/ready channels for instruction items and step results
// ----------------------------------------------------------------------------
interface xse_cmd_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  opcode_byte;
    logic [31:0] following_bytes;

    modport source (output valid, output req_type, output opcode_byte,
                    output following_bytes, input ready);
    modport sink   (input valid, input req_type, input opcode_byte,
                    input following_bytes, output ready);
endinterface

interface xse_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] next_pointer;
    logic [31:0] accumulator;

    modport source (output valid, output status, output next_pointer,
                    output accumulator, input ready);
    modport sink   (input valid, input status, input next_pointer,
                    input accumulator, output ready);
endinterface
`default_nettype wire

[rtl/xse_stack_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xse_stack_ram
// word stack memory, one write and one registered read port, write-first
// ----------------------------------------------------------------------------
module xse_stack_ram #(
    parameter int DEPTH = xse_pkg::STACK_WORDS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [31:0]   rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[rtl/xse_exec.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xse_exec
// decode and execute of one item: next architectural state and stack write
// ----------------------------------------------------------------------------
module xse_exec (
    input  wire logic                req_type,
    input  wire logic [7:0]          opcode_byte,
    input  wire logic [31:0]         following_bytes,
    input  wire xse_pkg::cpu_state_t cur,
    input  wire logic [31:0]         top_word,
    input  wire logic [31:0]         entry_address,
    input  wire logic [31:0]         code_bytes,
    input  wire logic [31:0]         usable,
    output xse_pkg::cpu_state_t      nxt,
    output xse_pkg::stk_wr_t         stk_wr
);

    always_comb
    begin
        logic [31:0]                   ip;
        logic [31:0]                   esp;
        logic [31:0]                   rel8;
        logic [xse_pkg::REG_IDX_W-1:0] dst;
        logic [xse_pkg::REG_IDX_W-1:0] src;
        logic [xse_pkg::REG_IDX_W-1:0] oreg;
        xse_pkg::status_t              st;

        nxt    = cur;
        stk_wr = '0;
        ip     = cur.ip;
        st     = xse_pkg::ST_RUN;
        esp    = cur.regs[xse_pkg::REG_ESP];
        dst    = following_bytes[2:0];
        src    = following_bytes[5:3];
        oreg   = opcode_byte[2:0];
        rel8   = {{24{following_bytes[7]}}, following_bytes[7:0]};

        if (req_type == xse_pkg::REQ_START)
        begin
            nxt.regs                   = '0;
            nxt.regs[xse_pkg::REG_ESP] = usable - 32'd4;
            nxt.ip                     = entry_address;
            nxt.stopped                = 1'b0;
            nxt.status                 = xse_pkg::ST_RUN;
        end
        else if (!cur.stopped)
        begin
            if (cur.ip >= code_bytes)
            begin
                st = xse_pkg::ST_BOUNDS;
            end
            else
            begin
                case (opcode_byte) inside
                    xse_pkg::OP_NOP:
                    begin
                        ip = cur.ip + 32'd1;
                    end
                    xse_pkg::OP_RET:
                    begin
                        st = xse_pkg::ST_HALT;
                    end
                    [xse_pkg::OP_MOV_L:xse_pkg::OP_MOV_H]:
                    begin
                        nxt.regs[oreg] = following_bytes;
                        ip = cur.ip + 32'd5;
                    end
                    xse_pkg::OP_ADD:
                    begin
                        nxt.regs[dst] = cur.regs[dst] + cur.regs[src];
                        ip = cur.ip + 32'd2;
                    end
                    xse_pkg::OP_SUB:
                    begin
                        nxt.regs[dst] = cur.regs[dst] - cur.regs[src];
                        ip = cur.ip + 32'd2;
                    end
                    [xse_pkg::OP_PUSH_L:xse_pkg::OP_PUSH_H]:
                    begin
                        esp = cur.regs[xse_pkg::REG_ESP] - 32'd4;
                        nxt.regs[xse_pkg::REG_ESP] = esp;
                        if (esp < usable)
                        begin
                            stk_wr.we   = 1'b1;
                            stk_wr.data = cur.regs[oreg];
                            ip = cur.ip + 32'd1;
                        end
                        else
                        begin
                            st = xse_pkg::ST_OVER;
                        end
                    end
                    [xse_pkg::OP_POP_L:xse_pkg::OP_POP_H]:
                    begin
                        if (esp < usable)
                        begin
                            nxt.regs[xse_pkg::REG_ESP] = esp + 32'd4;
                            nxt.regs[oreg] = top_word;
                            ip = cur.ip + 32'd1;
                        end
                        else
                        begin
                            st = xse_pkg::ST_UNDER;
                        end
                    end
                    xse_pkg::OP_CALL:
                    begin
                        if (($signed(following_bytes) > $signed(code_bytes))
                            || following_bytes[31])
                        begin
                            st = xse_pkg::ST_EXT;
                            ip = cur.ip + 32'd5;
                        end
                        else
                        begin
                            esp = cur.regs[xse_pkg::REG_ESP] - 32'd4;
                            nxt.regs[xse_pkg::REG_ESP] = esp;
                            if (esp < usable)
                            begin
                                stk_wr.we   = 1'b1;
                                stk_wr.data = cur.ip + 32'd5;
                                ip = cur.ip + following_bytes + 32'd5;
                            end
                            else
                            begin
                                st = xse_pkg::ST_OVER;
                            end
                        end
                    end
                    xse_pkg::OP_JMP:
                    begin
                        ip = cur.ip + rel8 + 32'd2;
                    end
                    default:
                    begin
                        st = xse_pkg::ST_BADOP;
                    end
                endcase
            end
            nxt.ip     = ip;
            nxt.status = st;
            if ((st != xse_pkg::ST_RUN) && (st != xse_pkg::ST_EXT))
            begin
                nxt.stopped = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/x86_subset_instruction_executor_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// x86_subset_instruction_executor_top
// executes one instruction of a small x86-32 subset per transfer
// a cmd transfer passes the input register and then the result register before
// rsp goes valid; both registers hold their item while rsp is not ready
// throughput: one item per cycle while rsp is ready; the execute stage is combinational
// the stack word under ESP is prefetched from the stack ram every cycle
// reset: registers and pointer zero, execution stopped with status halted,
// stack contents undefined until written
// ----------------------------------------------------------------------------
module x86_subset_instruction_executor_top #(
    parameter int STACK_WORDS = xse_pkg::STACK_WORDS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [xse_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [xse_pkg::CFG_DATA_W-1:0] wr_data,
    xse_cmd_if.sink                            cmd,
    xse_rsp_if.source                          rsp
);

    localparam int          AW        = (STACK_WORDS > 1) ? $clog2(STACK_WORDS) : 1;
    localparam logic [31:0] CAP_BYTES = 32'(STACK_WORDS * 4);

    logic [31:0]                       entry_reg;
    logic [31:0]                       code_reg;
    logic [xse_pkg::STACK_BYTES_W-1:0] stack_bytes_reg;
    logic [31:0]                       lim;
    logic [31:0]                       usable;

    logic        in_valid_reg;
    logic        req_reg;
    logic [7:0]  op_reg;
    logic [31:0] imm_reg;

    logic                out_valid_reg;
    xse_pkg::status_t    out_status_reg;
    logic [31:0]         out_ip_reg;
    logic [31:0]         out_acc_reg;

    xse_pkg::cpu_state_t state_reg;
    xse_pkg::cpu_state_t state_next;
    xse_pkg::stk_wr_t    stk_wr;
    logic [31:0]         top_word;
    logic                commit;
    logic                cmd_xfer;
    logic [AW-1:0]       raddr;
    logic [AW-1:0]       waddr;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg       <= '0;
            code_reg        <= '0;
            stack_bytes_reg <= xse_pkg::STACK_BYTES_W'(4096);
        end
        else if (wr_en)
        begin
            case (wr_index)
                xse_pkg::CFG_ENTRY: entry_reg <= wr_data;
                xse_pkg::CFG_CODE:  code_reg  <= wr_data;
                xse_pkg::CFG_STACK: stack_bytes_reg <= wr_data[xse_pkg::STACK_BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    assign lim    = {{(32 - xse_pkg::STACK_BYTES_W){1'b0}},
                     stack_bytes_reg[xse_pkg::STACK_BYTES_W-1:2], 2'b00};
    assign usable = (lim > CAP_BYTES) ? CAP_BYTES : lim;

    // pipeline control
    assign commit    = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !in_valid_reg || commit;
    assign cmd_xfer  = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            req_reg <= cmd.req_type;
            op_reg  <= cmd.opcode_byte;
            imm_reg <= cmd.following_bytes;
        end
    end

    xse_exec u_exec (
        .req_type        (req_reg),
        .opcode_byte     (op_reg),
        .following_bytes (imm_reg),
        .cur             (state_reg),
        .top_word        (top_word),
        .entry_address   (entry_reg),
        .code_bytes      (code_reg),
        .usable          (usable),
        .nxt             (state_next),
        .stk_wr          (stk_wr)
    );

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.regs    <= '0;
            state_reg.ip      <= '0;
            state_reg.stopped <= 1'b1;
            state_reg.status  <= xse_pkg::ST_HALT;
        end
        else if (commit)
        begin
            state_reg <= state_next;
        end
    end

    // stack word at ESP is read ahead for the next item
    assign waddr = state_next.regs[xse_pkg::REG_ESP][AW+1:2];
    assign raddr = commit ? state_next.regs[xse_pkg::REG_ESP][AW+1:2]
                          : state_reg.regs[xse_pkg::REG_ESP][AW+1:2];

    xse_stack_ram #(
        .DEPTH (STACK_WORDS),
        .AW    (AW)
    ) u_stack (
        .clk   (clk),
        .we    (commit && stk_wr.we),
        .waddr (waddr),
        .wdata (stk_wr.data),
        .raddr (raddr),
        .rdata (top_word)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_status_reg <= state_next.status;
            out_ip_reg     <= state_next.ip;
            out_acc_reg    <= state_next.regs[xse_pkg::REG_EAX];
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.next_pointer = out_ip_reg;
    assign rsp.accumulator  = out_acc_reg;

    // checks
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        commit && (req_reg == xse_pkg::REQ_START) |=> !state_reg.stopped)
        else $error("start transfer did not clear stop flag");

    a_stopped_holds: assert property (@(posedge clk) disable iff (!rst_n)
        commit && (req_reg == xse_pkg::REQ_EXEC) && state_reg.stopped
        |=> $stable(state_reg.regs) && $stable(state_reg.ip))
        else $error("stopped core changed state");

    a_error_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != xse_pkg::ST_RUN)
        && (out_status_reg != xse_pkg::ST_EXT) |-> state_reg.stopped)
        else $error("stopping status without stop flag");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> in_valid_reg && out_valid_reg && !rsp.ready)
        else $error("cmd stalled with free slot");

endmodule
`default_nettype wire
